// ----- src/assert_macros.svh -----
// assertion macros used by the top level rtl of the unicode stream decoder
// no dependencies; SYNTH selects the empty forms for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define UDEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udec assertion failed");

// next-cycle implication
`define UDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udec assertion failed");

`else

`define UDEC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/udec_pkg.sv -----
// types, codes and constants of the unicode stream decoder
// no dependencies; used by every other rtl file but assert_macros.svh
`default_nettype none

package udec_pkg;

    localparam int MODE_W             = 3;
    localparam int BYTE_W             = 8;
    localparam int CP_W               = 21;
    localparam int ERR_W              = 3;
    localparam int POS_OUT_W          = 24;
    localparam int ACC_W              = 32;
    localparam int CNT_W              = 3;
    localparam int HS_W               = 10;
    localparam int POSITION_WIDTH_DEF = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_UTF8     = 3'd0,
        MODE_UTF16_BE = 3'd1,
        MODE_UTF16_LE = 3'd2,
        MODE_UTF32_BE = 3'd3,
        MODE_UTF32_LE = 3'd4
    } udec_mode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE          = 3'd0,
        ERR_BAD_LEAD      = 3'd1,
        ERR_BAD_FOLLOW    = 3'd2,
        ERR_PREMATURE_END = 3'd3,
        ERR_BAD_HIGH_SUR  = 3'd4,
        ERR_BAD_LOW_SUR   = 3'd5,
        ERR_INVALID_CP    = 3'd6
    } udec_err_t;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // surrogate ranges of a utf-16 unit
    localparam logic [15:0] UNIT_SUR_MIN = 16'hD800;
    localparam logic [15:0] UNIT_HI_MAX  = 16'hDBFF;
    localparam logic [15:0] UNIT_LO_MIN  = 16'hDC00;
    localparam logic [15:0] UNIT_SUR_MAX = 16'hDFFF;

    // scalar limits and line break characters
    localparam logic [ACC_W-1:0] CP_MAX     = 32'h0010FFFF;
    localparam logic [ACC_W-1:0] CP_SUR_MIN = 32'h0000D800;
    localparam logic [ACC_W-1:0] CP_SUR_MAX = 32'h0000DFFF;
    localparam logic [CP_W-1:0]  SUPP_BASE  = 21'h10000;
    localparam logic [ACC_W-1:0] CH_LF      = 32'h0000000A;
    localparam logic [ACC_W-1:0] CH_VT      = 32'h0000000B;
    localparam logic [ACC_W-1:0] CH_FF      = 32'h0000000C;
    localparam logic [ACC_W-1:0] CH_CR      = 32'h0000000D;
    localparam logic [ACC_W-1:0] CH_NEL     = 32'h00000085;
    localparam logic [ACC_W-1:0] CH_LS      = 32'h00002028;
    localparam logic [ACC_W-1:0] CH_PS      = 32'h00002029;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] data_byte;
    } udec_item_t;

    // partial sequence state; seen == 0 means idle
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] seen;
        logic [CNT_W-1:0] needed;
        logic [HS_W-1:0]  hs;
    } udec_seq_t;

    // outcome of one request, handed from the step logic to the top level
    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        udec_err_t       error_code;
        logic            stream_end;
        logic            advance;
        logic            line_brk;
        logic            cr_write;
        logic            cr_value;
    } udec_res_t;

endpackage

`default_nettype wire

// ----- src/udec_if.sv -----
// request and result channel interfaces of the unicode stream decoder
// depends on udec_pkg for field widths
`default_nettype none

interface udec_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [udec_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface udec_res_if;
    logic                          valid;
    logic                          ready;
    logic [udec_pkg::CP_W-1:0]     code_point;
    logic [udec_pkg::ERR_W-1:0]    error_code;
    logic [udec_pkg::POS_OUT_W-1:0] line_number;
    logic [udec_pkg::POS_OUT_W-1:0] column_number;
    logic                          stream_end;

    modport source (
        output valid, output code_point, output error_code,
        output line_number, output column_number, output stream_end,
        input ready
    );
    modport sink (
        input valid, input code_point, input error_code,
        input line_number, input column_number, input stream_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/udec_in_reg.sv -----
// input register stage: holds one request until the decode stage takes it
// depends on udec_pkg
`default_nettype none

module udec_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  udec_pkg::udec_item_t in_item,
    output logic                 in_ready,
    input  logic                 take,
    output logic                 out_valid,
    output udec_pkg::udec_item_t out_item
);

    logic                 valid_reg;
    udec_pkg::udec_item_t item_reg;

    // refill in the same cycle the held request moves on
    assign in_ready  = !valid_reg || take;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/udec_step.sv -----
// decode logic for one request: next sequence state and the result, if any
// depends on udec_pkg
`default_nettype none

module udec_step (
    input  udec_pkg::udec_item_t              item,
    input  logic [udec_pkg::MODE_W-1:0]       mode,
    input  udec_pkg::udec_seq_t               seq,
    input  logic                              prev_cr,
    output udec_pkg::udec_seq_t               seq_next,
    output udec_pkg::udec_res_t               res
);

    logic [udec_pkg::BYTE_W-1:0] b;
    logic [15:0]                 unit;
    logic                        big;
    logic [udec_pkg::ACC_W-1:0]  u8_word;
    logic [udec_pkg::ACC_W-1:0]  u32_base;
    logic [udec_pkg::ACC_W-1:0]  u32_word;
    logic [udec_pkg::ACC_W-1:0]  emit_cp;
    logic [udec_pkg::CNT_W-1:0]  u8_rem;
    logic [4:0]                  u8_shift;
    logic [4:0]                  le_shift;
    logic                        do_emit;
    logic                        do_fail;
    udec_pkg::udec_err_t         fail_code;
    udec_pkg::udec_seq_t         seq_step;
    logic                        bad_cp;
    logic                        brk;

    always_comb
    begin
        b         = item.data_byte;
        seq_step  = seq;
        unit      = '0;
        big       = 1'b0;
        u8_word   = '0;
        u32_base  = '0;
        u32_word  = '0;
        u8_rem    = '0;
        u8_shift  = '0;
        le_shift  = '0;
        emit_cp   = '0;
        do_emit   = 1'b0;
        do_fail   = 1'b0;
        fail_code = udec_pkg::ERR_NONE;

        case (udec_pkg::udec_mode_t'(mode))
            udec_pkg::MODE_UTF16_BE, udec_pkg::MODE_UTF16_LE:
            begin
                big = (udec_pkg::udec_mode_t'(mode) == udec_pkg::MODE_UTF16_BE);
                if (!seq.seen[0])
                begin
                    // first byte of a unit
                    seq_step.acc = big ? {16'b0, b, 8'b0} : {24'b0, b};
                    if (seq.seen == '0)
                    begin
                        seq_step.needed = 3'd2;
                    end
                    seq_step.seen = seq.seen + 3'd1;
                end
                else
                begin
                    unit = big ? (seq.acc[15:0] | {8'b0, b}) : (seq.acc[15:0] | {b, 8'b0});
                    seq_step.seen = seq.seen + 3'd1;
                    if (seq.seen == 3'd1)
                    begin
                        if (unit < udec_pkg::UNIT_SUR_MIN || unit > udec_pkg::UNIT_SUR_MAX)
                        begin
                            do_emit = 1'b1;
                            emit_cp = {16'b0, unit};
                        end
                        else if (unit > udec_pkg::UNIT_HI_MAX)
                        begin
                            do_fail   = 1'b1;
                            fail_code = udec_pkg::ERR_BAD_HIGH_SUR;
                        end
                        else
                        begin
                            seq_step.hs     = unit[9:0];
                            seq_step.needed = 3'd4;
                            seq_step.acc    = '0;
                        end
                    end
                    else if (unit < udec_pkg::UNIT_LO_MIN || unit > udec_pkg::UNIT_SUR_MAX)
                    begin
                        do_fail   = 1'b1;
                        fail_code = udec_pkg::ERR_BAD_LOW_SUR;
                    end
                    else
                    begin
                        // supplementary plane from the surrogate pair
                        do_emit = 1'b1;
                        emit_cp = {11'b0, udec_pkg::SUPP_BASE + {1'b0, seq.hs, unit[9:0]}};
                    end
                end
            end
            udec_pkg::MODE_UTF32_BE, udec_pkg::MODE_UTF32_LE:
            begin
                u32_base = (seq.seen == '0) ? '0 : seq.acc;
                if (seq.seen == '0)
                begin
                    seq_step.needed = 3'd4;
                end
                le_shift = {seq.seen[1:0], 3'b000};
                if (udec_pkg::udec_mode_t'(mode) == udec_pkg::MODE_UTF32_BE)
                begin
                    u32_word = {u32_base[23:0], b};
                end
                else
                begin
                    u32_word = u32_base | ({24'b0, b} << le_shift);
                end
                seq_step.acc  = u32_word;
                seq_step.seen = seq.seen + 3'd1;
                if (seq.seen >= 3'd3)
                begin
                    do_emit = 1'b1;
                    emit_cp = u32_word;
                end
            end
            default:
            begin
                // utf-8, also for the unused mode codes
                if (seq.seen == '0)
                begin
                    if (!b[7])
                    begin
                        do_emit = 1'b1;
                        emit_cp = {24'b0, b};
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        seq_step.acc    = {21'b0, b[4:0], 6'b0};
                        seq_step.needed = 3'd2;
                        seq_step.seen   = 3'd1;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        seq_step.acc    = {16'b0, b[3:0], 12'b0};
                        seq_step.needed = 3'd3;
                        seq_step.seen   = 3'd1;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        seq_step.acc    = {11'b0, b[2:0], 18'b0};
                        seq_step.needed = 3'd4;
                        seq_step.seen   = 3'd1;
                    end
                    else
                    begin
                        do_fail   = 1'b1;
                        fail_code = udec_pkg::ERR_BAD_LEAD;
                    end
                end
                else if (b[7:6] != 2'b10)
                begin
                    do_fail   = 1'b1;
                    fail_code = udec_pkg::ERR_BAD_FOLLOW;
                end
                else
                begin
                    u8_rem = seq.needed - seq.seen - 3'd1;
                    if ({1'b0, seq.needed} > ({1'b0, seq.seen} + 4'd1))
                    begin
                        case (u8_rem)
                            3'd1:    u8_shift = 5'd6;
                            3'd2:    u8_shift = 5'd12;
                            default: u8_shift = 5'd0;
                        endcase
                    end
                    u8_word       = seq.acc | ({26'b0, b[5:0]} << u8_shift);
                    seq_step.acc  = u8_word;
                    seq_step.seen = seq.seen + 3'd1;
                    if (({1'b0, seq.seen} + 4'd1) >= {1'b0, seq.needed})
                    begin
                        do_emit = 1'b1;
                        emit_cp = u8_word;
                    end
                end
            end
        endcase
    end

    assign bad_cp = (emit_cp > udec_pkg::CP_MAX) ||
                    (emit_cp >= udec_pkg::CP_SUR_MIN && emit_cp <= udec_pkg::CP_SUR_MAX);

    assign brk = (emit_cp == udec_pkg::CH_VT) || (emit_cp == udec_pkg::CH_FF) ||
                 (emit_cp == udec_pkg::CH_CR) || (emit_cp == udec_pkg::CH_NEL) ||
                 (emit_cp == udec_pkg::CH_LS) || (emit_cp == udec_pkg::CH_PS) ||
                 (emit_cp == udec_pkg::CH_LF && !prev_cr);

    always_comb
    begin
        seq_next = seq_step;
        res      = '0;

        if (item.req_type == udec_pkg::REQ_END)
        begin
            seq_next       = '0;
            res.valid      = 1'b1;
            res.error_code = (seq.seen != '0) ? udec_pkg::ERR_PREMATURE_END
                                              : udec_pkg::ERR_NONE;
            res.stream_end = 1'b1;
            res.cr_write   = 1'b1;
            res.cr_value   = 1'b0;
        end
        else if (do_fail)
        begin
            seq_next       = '0;
            res.valid      = 1'b1;
            res.error_code = fail_code;
        end
        else if (do_emit)
        begin
            seq_next  = '0;
            res.valid = 1'b1;
            if (bad_cp)
            begin
                res.error_code = udec_pkg::ERR_INVALID_CP;
            end
            else
            begin
                res.code_point = emit_cp[udec_pkg::CP_W-1:0];
                res.advance    = 1'b1;
                res.line_brk   = brk;
                res.cr_write   = 1'b1;
                res.cr_value   = (emit_cp == udec_pkg::CH_CR);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/utf_multi_format_decoder.sv -----
// top level of the unicode stream decoder: input stage, decode, position and result registers
// depends on udec_pkg, udec_if, udec_in_reg, udec_step and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Byte-serial Unicode decoder. One raw byte (or an end-of-stream marker) arrives per
// request and is decoded as UTF-8, UTF-16 BE/LE or UTF-32 BE/LE as selected by the
// encoding register (codes 5 to 7 decode as UTF-8). Every finished code point, every
// malformed sequence and every end marker produces exactly one result carrying the
// scalar value (zero on error or end), an error code and the line and column position
// after that character; bytes in the middle of a sequence produce no result.
// Throughput is one request per clock while results are taken: a request sits in the
// input register, the decode step is a single pass of combinational logic against the
// sequence state, and the result lands in the output register. The output register is
// freed in the cycle it is taken, so a stalled result only holds the pipe while the
// sink keeps ready low. Writing the encoding register drops any partial sequence and
// must only happen while the block is idle.
// Line and column counters are POSITION_WIDTH bits wide and wrap; the ports show
// their low 24 bits.
module utf_multi_format_decoder #(
    parameter int POSITION_WIDTH = udec_pkg::POSITION_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    udec_req_if.sink                    req,
    udec_res_if.source                  rsp,
    input  logic                        cfg_we,
    input  logic [udec_pkg::MODE_W-1:0] cfg_wdata
);

    // input stage
    logic                 item_valid;
    udec_pkg::udec_item_t item;
    logic                 take;

    // decode state
    logic [udec_pkg::MODE_W-1:0] mode_reg;
    udec_pkg::udec_seq_t         seq_reg;
    udec_pkg::udec_seq_t         seq_next;
    logic                        cr_reg;
    udec_pkg::udec_res_t         step_res;

    // position counters
    logic [POSITION_WIDTH-1:0] line_reg;
    logic [POSITION_WIDTH-1:0] col_reg;
    logic [POSITION_WIDTH-1:0] line_next;
    logic [POSITION_WIDTH-1:0] col_next;

    // result register
    logic                           res_valid_reg;
    logic [udec_pkg::CP_W-1:0]      cp_reg;
    udec_pkg::udec_err_t            err_reg;
    logic [udec_pkg::POS_OUT_W-1:0] line_out_reg;
    logic [udec_pkg::POS_OUT_W-1:0] col_out_reg;
    logic                           end_reg;
    logic                           out_free;

    // the decode stage moves whenever the result register can take its outcome
    assign out_free = !res_valid_reg || rsp.ready;
    assign take     = item_valid && out_free;

    udec_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_item   ({req.req_type, req.data_byte}),
        .in_ready  (req.ready),
        .take      (take),
        .out_valid (item_valid),
        .out_item  (item)
    );

    udec_step u_step (
        .item     (item),
        .mode     (mode_reg),
        .seq      (seq_reg),
        .prev_cr  (cr_reg),
        .seq_next (seq_next),
        .res      (step_res)
    );

    // a break starts a new line and puts itself at column 1; every other character steps the column
    always_comb
    begin
        line_next = line_reg;
        col_next  = col_reg;
        if (step_res.advance)
        begin
            if (step_res.line_brk)
            begin
                line_next = line_reg + POSITION_WIDTH'(1);
                col_next  = POSITION_WIDTH'(1);
            end
            else
            begin
                col_next = col_reg + POSITION_WIDTH'(1);
            end
        end
    end

    // sequence state and encoding register; a config write restarts the sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= udec_pkg::MODE_UTF8;
            seq_reg  <= '0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
            seq_reg  <= '0;
        end
        else if (take)
        begin
            seq_reg <= seq_next;
        end
    end

    // positions and cr tracking only change on a good character or an end marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_reg   <= 1'b0;
            line_reg <= '0;
            col_reg  <= '0;
        end
        else if (take)
        begin
            if (step_res.cr_write)
            begin
                cr_reg <= step_res.cr_value;
            end
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    // result valid: loads on a decode with an outcome, clears once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= step_res.valid;
        end
        else if (rsp.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload, positions as they stand after this character
    always_ff @(posedge clk)
    begin
        if (take && step_res.valid)
        begin
            cp_reg       <= step_res.code_point;
            err_reg      <= step_res.error_code;
            line_out_reg <= udec_pkg::POS_OUT_W'(line_next);
            col_out_reg  <= udec_pkg::POS_OUT_W'(col_next);
            end_reg      <= step_res.stream_end;
        end
    end

    assign rsp.valid         = res_valid_reg;
    assign rsp.code_point    = cp_reg;
    assign rsp.error_code    = err_reg;
    assign rsp.line_number   = line_out_reg;
    assign rsp.column_number = col_out_reg;
    assign rsp.stream_end    = end_reg;

    // a sequence never holds more than four bytes
    `UDEC_ASSERT_IMPL(a_seen_bound, clk, rst_n, 1'b1, seq_reg.seen <= 3'd4)

    // an end marker always leaves the decoder idle with cr tracking cleared
    `UDEC_ASSERT_NEXT(a_end_idle, clk, rst_n, take && item.req_type == udec_pkg::REQ_END && !cfg_we, seq_reg.seen == '0 && !cr_reg)

    // an error never moves the position counters
    `UDEC_ASSERT_NEXT(a_err_pos_hold, clk, rst_n, take && step_res.valid && step_res.error_code != udec_pkg::ERR_NONE, line_reg == $past(line_reg) && col_reg == $past(col_reg))

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for utf_multi_format_decoder: directed table, then random byte streams
// depends on udec_pkg, udec_if and the decoder rtl; predicts results with its own model, typed rows apart
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES    = 120;   // long receiver hold-off, fills the pipe
    localparam int SETTLE_CYCLES  = 6;     // margin for the pipe to settle after the last result
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request and no result accepted
    localparam int RANDOM_ITEMS   = 1800;
    localparam int MAX_REPORTS    = 10;

    // unused encoding code, decodes as utf-8
    localparam logic [udec_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;

    // one decoded character, error or end marker as seen on the result channel
    typedef struct packed {
        logic [udec_pkg::CP_W-1:0]      cp;
        udec_pkg::udec_err_t            err;
        logic [udec_pkg::POS_OUT_W-1:0] line;
        logic [udec_pkg::POS_OUT_W-1:0] col;
        logic                           last;
    } char_res_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic [udec_pkg::MODE_W-1:0] mode;
        logic                        rtype;
        logic [udec_pkg::BYTE_W-1:0] b;
        bit                          typed;
        char_res_t                   want;
    } dir_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [udec_pkg::MODE_W-1:0] cfg_wdata;

    udec_req_if req_ch ();
    udec_res_if rsp_ch ();

    utf_multi_format_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // characters the decoder still owes us, oldest first
    char_res_t chars_due[$];
    dir_row_t  dir_tab[$];

    int errors = 0;
    int reports = 0;
    int accepted_reqs = 0;
    int holds_asked = 0;
    int hold_cnt = 0;
    bit no_idle = 1'b0;

    // decoder state as we expect it to be
    logic [udec_pkg::MODE_W-1:0]    mode_now;
    logic [udec_pkg::ACC_W-1:0]     acc;
    logic [udec_pkg::CNT_W-1:0]     seq_seen;
    logic [udec_pkg::CNT_W-1:0]     seq_need;
    logic [udec_pkg::HS_W-1:0]      hi_bits;
    logic                           after_cr;
    logic [udec_pkg::POS_OUT_W-1:0] line_cnt;
    logic [udec_pkg::POS_OUT_W-1:0] col_cnt;

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------- prediction

    function automatic void seq_clear();
        acc      = '0;
        seq_seen = '0;
        seq_need = '0;
        hi_bits  = '0;
    endfunction

    // malformed input: position untouched, partial sequence dropped
    function automatic char_res_t char_error(input udec_pkg::udec_err_t e);
        char_res_t r;
        seq_clear();
        r      = '0;
        r.err  = e;
        r.line = line_cnt;
        r.col  = col_cnt;
        return r;
    endfunction

    // finished scalar: range check, then line and column update
    function automatic char_res_t char_done(input logic [udec_pkg::ACC_W-1:0] v);
        char_res_t r;
        logic      brk;
        seq_clear();
        if (v > udec_pkg::CP_MAX || (v >= udec_pkg::CP_SUR_MIN && v <= udec_pkg::CP_SUR_MAX))
            return char_error(udec_pkg::ERR_INVALID_CP);
        brk = (v == udec_pkg::CH_VT || v == udec_pkg::CH_FF || v == udec_pkg::CH_CR ||
               v == udec_pkg::CH_NEL || v == udec_pkg::CH_LS || v == udec_pkg::CH_PS ||
               (v == udec_pkg::CH_LF && !after_cr));
        if (brk)
        begin
            line_cnt++;
            col_cnt = '0;
        end
        col_cnt++;
        after_cr = (v == udec_pkg::CH_CR);
        r      = '0;
        r.cp   = v[udec_pkg::CP_W-1:0];
        r.err  = udec_pkg::ERR_NONE;
        r.line = line_cnt;
        r.col  = col_cnt;
        return r;
    endfunction

    function automatic bit step8(input logic [udec_pkg::BYTE_W-1:0] b, output char_res_t res);
        int sh;
        res = '0;
        if (seq_seen == 0)
        begin
            if (b < 8'h80)
            begin
                res = char_done({24'b0, b});
                return 1'b1;
            end
            if (b[7:5] == 3'b110)
            begin
                acc      = {21'b0, b[4:0], 6'b0};
                seq_need = 3'd2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                acc      = {16'b0, b[3:0], 12'b0};
                seq_need = 3'd3;
            end
            else if (b[7:3] == 5'b11110)
            begin
                acc      = {11'b0, b[2:0], 18'b0};
                seq_need = 3'd4;
            end
            else
            begin
                res = char_error(udec_pkg::ERR_BAD_LEAD);
                return 1'b1;
            end
            seq_seen = 3'd1;
            return 1'b0;
        end
        if (b[7:6] != 2'b10)
        begin
            res = char_error(udec_pkg::ERR_BAD_FOLLOW);
            return 1'b1;
        end
        sh = (int'(seq_need) > int'(seq_seen) + 1) ?
             6 * (int'(seq_need) - 1 - int'(seq_seen)) : 0;
        acc = acc | ({26'b0, b[5:0]} << sh);
        seq_seen++;
        if (seq_seen >= seq_need)
        begin
            res = char_done(acc);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit step16(input logic [udec_pkg::BYTE_W-1:0] b, input bit big,
                                  output char_res_t res);
        logic [15:0] unit;
        res = '0;
        // first byte of a unit only waits
        if (seq_seen[0] == 1'b0)
        begin
            acc = big ? {16'b0, b, 8'b0} : {24'b0, b};
            if (seq_seen == 0)
                seq_need = 3'd2;
            seq_seen++;
            return 1'b0;
        end
        unit = big ? (acc[15:0] | {8'b0, b}) : (acc[15:0] | {b, 8'b0});
        seq_seen++;
        if (seq_seen <= 3'd2)
        begin
            if (unit < udec_pkg::UNIT_SUR_MIN || unit > udec_pkg::UNIT_SUR_MAX)
            begin
                res = char_done({16'b0, unit});
                return 1'b1;
            end
            // low surrogate where a high one belongs
            if (unit > udec_pkg::UNIT_HI_MAX)
            begin
                res = char_error(udec_pkg::ERR_BAD_HIGH_SUR);
                return 1'b1;
            end
            hi_bits  = unit[9:0];
            seq_need = 3'd4;
            acc      = '0;
            return 1'b0;
        end
        if (unit < udec_pkg::UNIT_LO_MIN || unit > udec_pkg::UNIT_SUR_MAX)
        begin
            res = char_error(udec_pkg::ERR_BAD_LOW_SUR);
            return 1'b1;
        end
        res = char_done({11'b0, udec_pkg::SUPP_BASE} + {12'b0, hi_bits, unit[9:0]});
        return 1'b1;
    endfunction

    function automatic bit step32(input logic [udec_pkg::BYTE_W-1:0] b, input bit big,
                                  output char_res_t res);
        res = '0;
        if (seq_seen == 0)
        begin
            acc      = '0;
            seq_need = 3'd4;
        end
        if (big)
            acc = {acc[23:0], b};
        else
            acc = acc | ({24'b0, b} << (8 * int'(seq_seen[1:0])));
        seq_seen++;
        if (seq_seen >= 3'd4)
        begin
            res = char_done(acc);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // expected outcome of one accepted request; returns 1 when a result is due
    function automatic bit decode_req(input logic rtype, input logic [udec_pkg::BYTE_W-1:0] b,
                                      output char_res_t res);
        res = '0;
        if (rtype == udec_pkg::REQ_END)
        begin
            res.err = (seq_seen != 0) ? udec_pkg::ERR_PREMATURE_END : udec_pkg::ERR_NONE;
            seq_clear();
            after_cr = 1'b0;
            res.line = line_cnt;
            res.col  = col_cnt;
            res.last = 1'b1;
            return 1'b1;
        end
        if (mode_now == udec_pkg::MODE_UTF16_BE)
            return step16(b, 1'b1, res);
        if (mode_now == udec_pkg::MODE_UTF16_LE)
            return step16(b, 1'b0, res);
        if (mode_now == udec_pkg::MODE_UTF32_BE)
            return step32(b, 1'b1, res);
        if (mode_now == udec_pkg::MODE_UTF32_LE)
            return step32(b, 1'b0, res);
        return step8(b, res);   // utf-8 and the unused codes
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic dir_row_t plain_row(input logic [udec_pkg::MODE_W-1:0] m,
                                           input logic rt,
                                           input logic [udec_pkg::BYTE_W-1:0] b);
        dir_row_t d;
        d.mode  = m;
        d.rtype = rt;
        d.b     = b;
        d.typed = 1'b0;
        d.want  = '0;
        return d;
    endfunction

    function automatic dir_row_t typed_row(input logic [udec_pkg::MODE_W-1:0] m,
                                           input logic rt,
                                           input logic [udec_pkg::BYTE_W-1:0] b,
                                           input logic [udec_pkg::CP_W-1:0] cp,
                                           input udec_pkg::udec_err_t e,
                                           input logic [udec_pkg::POS_OUT_W-1:0] ln,
                                           input logic [udec_pkg::POS_OUT_W-1:0] col,
                                           input logic last);
        dir_row_t d;
        d           = plain_row(m, rt, b);
        d.typed     = 1'b1;
        d.want.cp   = cp;
        d.want.err  = e;
        d.want.line = ln;
        d.want.col  = col;
        d.want.last = last;
        return d;
    endfunction

    // random scalar, weighted toward the interesting classes
    function automatic logic [udec_pkg::ACC_W-1:0] pick_scalar();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return $urandom_range(0, 32'h7F);
        if (r < 37)
        begin
            case ($urandom_range(0, 6))
                0: return udec_pkg::CH_LF;
                1: return udec_pkg::CH_VT;
                2: return udec_pkg::CH_FF;
                3: return udec_pkg::CH_CR;
                4: return udec_pkg::CH_NEL;
                5: return udec_pkg::CH_LS;
                default: return udec_pkg::CH_PS;
            endcase
        end
        if (r < 52)
            return $urandom_range(32'h80, 32'h7FF);
        if (r < 64)
            return $urandom_range(32'h800, 32'hD7FF);
        if (r < 70)
            return $urandom_range(32'hE000, 32'hFFFF);
        if (r < 88)
            return $urandom_range(32'h10000, 32'h10FFFF);
        if (r < 93)
            return $urandom_range(32'hD800, 32'hDFFF);
        if (r < 97)
            return $urandom_range(32'h110000, 32'h1FFFFF);
        return $urandom();
    endfunction

    // append the byte form of v in the given encoding
    function automatic void encode(input logic [udec_pkg::MODE_W-1:0] mode,
                                   input logic [udec_pkg::ACC_W-1:0] v,
                                   ref logic [udec_pkg::BYTE_W-1:0] q[$]);
        logic [udec_pkg::ACC_W-1:0] x;
        logic [15:0]                u0;
        logic [15:0]                u1;
        bit                         pair;
        int                         n;
        if (mode == udec_pkg::MODE_UTF16_BE || mode == udec_pkg::MODE_UTF16_LE)
        begin
            pair = (v > 32'hFFFF && v <= udec_pkg::CP_MAX);
            x    = v - 32'h10000;
            u0   = pair ? (udec_pkg::UNIT_SUR_MIN | {6'b0, x[19:10]}) : v[15:0];
            u1   = udec_pkg::UNIT_LO_MIN | {6'b0, x[9:0]};
            if (mode == udec_pkg::MODE_UTF16_BE)
            begin
                q.push_back(u0[15:8]);
                q.push_back(u0[7:0]);
                if (pair)
                begin
                    q.push_back(u1[15:8]);
                    q.push_back(u1[7:0]);
                end
            end
            else
            begin
                q.push_back(u0[7:0]);
                q.push_back(u0[15:8]);
                if (pair)
                begin
                    q.push_back(u1[7:0]);
                    q.push_back(u1[15:8]);
                end
            end
        end
        else if (mode == udec_pkg::MODE_UTF32_BE)
        begin
            q.push_back(v[31:24]);
            q.push_back(v[23:16]);
            q.push_back(v[15:8]);
            q.push_back(v[7:0]);
        end
        else if (mode == udec_pkg::MODE_UTF32_LE)
        begin
            q.push_back(v[7:0]);
            q.push_back(v[15:8]);
            q.push_back(v[23:16]);
            q.push_back(v[31:24]);
        end
        else
        begin
            // utf-8 reaches 21 bits; now and then an overlong form
            v = {11'b0, v[20:0]};
            n = (v < 32'h80) ? 1 : (v < 32'h800) ? 2 : (v < 32'h10000) ? 3 : 4;
            if (n < 4 && $urandom_range(0, 19) == 0)
                n++;
            case (n)
                1: q.push_back(v[7:0]);
                2:
                begin
                    q.push_back({3'b110, v[10:6]});
                    q.push_back({2'b10, v[5:0]});
                end
                3:
                begin
                    q.push_back({4'b1110, v[15:12]});
                    q.push_back({2'b10, v[11:6]});
                    q.push_back({2'b10, v[5:0]});
                end
                default:
                begin
                    q.push_back({5'b11110, v[20:18]});
                    q.push_back({2'b10, v[17:12]});
                    q.push_back({2'b10, v[11:6]});
                    q.push_back({2'b10, v[5:0]});
                end
            endcase
        end
    endfunction

    // ---------------------------------------------------------------- request side

    // offer one request, hold it until taken, then record what it should produce
    task automatic send_req(input logic rtype, input logic [udec_pkg::BYTE_W-1:0] b,
                            input bit typed, input char_res_t want);
        int        gap;
        char_res_t res;
        // during a hold-off keep offering back to back so the pipe backs up
        gap = (no_idle || hold_cnt > 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rtype;
        req_ch.data_byte <= b;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        accepted_reqs++;
        if (decode_req(rtype, b, res))
            chars_due.push_back(typed ? want : res);
    endtask

    // stop offering, wait for every owed result, then let the pipe settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // encoding write; the decoder drops any partial sequence
    task automatic write_mode(input logic [udec_pkg::MODE_W-1:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_now = m;
        seq_clear();
    endtask

    // one random character, sometimes damaged, cut short, or replaced by noise or an end
    task automatic send_char(input logic [udec_pkg::MODE_W-1:0] mode);
        logic [udec_pkg::BYTE_W-1:0] bytes_q[$];
        logic [udec_pkg::ACC_W-1:0]  v;
        int                          r;
        int                          keep;
        bit                          end_after;
        end_after = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            send_req(udec_pkg::REQ_END, 8'($urandom), 1'b0, '0);
            return;
        end
        if (r < 9)
        begin
            repeat ($urandom_range(1, 3)) send_req(udec_pkg::REQ_DATA, 8'($urandom), 1'b0, '0);
            return;
        end
        v = pick_scalar();
        encode(mode, v, bytes_q);
        // cr lf pair, the lf must not count as a second break
        if (v == udec_pkg::CH_CR && $urandom_range(0, 1) == 1)
            encode(mode, udec_pkg::CH_LF, bytes_q);
        r = $urandom_range(0, 99);
        if (r < 6)
            bytes_q[$urandom_range(0, bytes_q.size() - 1)] = 8'($urandom);
        else if (r < 12 && bytes_q.size() > 1)
        begin
            keep = $urandom_range(1, bytes_q.size() - 1);
            while (bytes_q.size() > keep)
                void'(bytes_q.pop_back());
            end_after = (r < 9);
        end
        foreach (bytes_q[i])
            send_req(udec_pkg::REQ_DATA, bytes_q[i], 1'b0, '0);
        if (end_after)
            send_req(udec_pkg::REQ_END, 8'($urandom), 1'b0, '0);
    endtask

    // ---------------------------------------------------------------- result side

    task automatic check_result();
        char_res_t want;
        if (chars_due.size() == 0)
        begin
            errors++;
            if (reports < MAX_REPORTS)
                $display("unexpected result: cp %h err %0d line %0d col %0d end %0b",
                         rsp_ch.code_point, rsp_ch.error_code, rsp_ch.line_number,
                         rsp_ch.column_number, rsp_ch.stream_end);
            reports++;
            return;
        end
        want = chars_due.pop_front();
        if (rsp_ch.code_point !== want.cp || rsp_ch.error_code !== want.err ||
            rsp_ch.line_number !== want.line || rsp_ch.column_number !== want.col ||
            rsp_ch.stream_end !== want.last)
        begin
            errors++;
            if (reports < MAX_REPORTS)
                $display("mismatch (exp/got): cp %h/%h err %0d/%0d ",
                         want.cp, rsp_ch.code_point, want.err, rsp_ch.error_code,
                         "line %0d/%0d col %0d/%0d end %0b/%0b",
                         want.line, rsp_ch.line_number, want.col, rsp_ch.column_number,
                         want.last, rsp_ch.stream_end);
            reports++;
        end
    endtask

    // receiver: checks each taken result, then picks ready for the next edge
    initial
    begin
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                check_result();
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_cnt   = HOLD_CYCLES;
            end
            if (rst_n !== 1'b1)
                rsp_ch.ready <= 1'b0;
            else if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = no_idle ? 0 : pick_gap();
            end
        end
    end

    // watchdog: too long with nothing moving on either channel
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                stuck = 0;
            else
                stuck++;
        end
        $display("utf_multi_format_decoder test failed");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        int                          rand_base;
        int                          next_hold;
        int                          quota;
        int                          start;
        int                          ph;
        logic [udec_pkg::MODE_W-1:0] m;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = udec_pkg::REQ_DATA;
        req_ch.data_byte = '0;

        mode_now = udec_pkg::MODE_UTF8;
        seq_clear();
        after_cr = 1'b0;
        line_cnt = '0;
        col_cnt  = '0;

        // utf-8 from reset: end while idle, cr then lf, bad lead, bad follow,
        // scalar above the top of the range, end inside a sequence
        dir_tab.push_back(typed_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_END, 8'hA5, '0,
                                    udec_pkg::ERR_NONE, 24'd0, 24'd0, 1'b1));
        dir_tab.push_back(typed_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'h0D, 21'h0D,
                                    udec_pkg::ERR_NONE, 24'd1, 24'd1, 1'b0));
        dir_tab.push_back(typed_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'h0A, 21'h0A,
                                    udec_pkg::ERR_NONE, 24'd1, 24'd2, 1'b0));
        dir_tab.push_back(typed_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'hFF, '0,
                                    udec_pkg::ERR_BAD_LEAD, 24'd1, 24'd2, 1'b0));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'hC3));
        dir_tab.push_back(typed_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'h28, '0,
                                    udec_pkg::ERR_BAD_FOLLOW, 24'd1, 24'd2, 1'b0));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'hF4));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'h90));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'h80));
        dir_tab.push_back(typed_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'h80, '0,
                                    udec_pkg::ERR_INVALID_CP, 24'd1, 24'd2, 1'b0));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_DATA, 8'hF0));
        dir_tab.push_back(typed_row(udec_pkg::MODE_UTF8, udec_pkg::REQ_END, 8'h00, '0,
                                    udec_pkg::ERR_PREMATURE_END, 24'd1, 24'd2, 1'b1));
        // utf-16 be: surrogate pair, lone low surrogate, high followed by a plain unit,
        // then a half unit left hanging across the encoding change
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'hD8));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'h00));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'hDC));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'h00));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'hDC));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'h00));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'hD8));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'h00));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'h00));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'h41));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF16_BE, udec_pkg::REQ_DATA, 8'hD8));
        // utf-32 le: largest valid scalar
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF32_LE, udec_pkg::REQ_DATA, 8'hFF));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF32_LE, udec_pkg::REQ_DATA, 8'hFF));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF32_LE, udec_pkg::REQ_DATA, 8'h10));
        dir_tab.push_back(plain_row(udec_pkg::MODE_UTF32_LE, udec_pkg::REQ_DATA, 8'h00));
        // unused encoding code behaves as utf-8
        dir_tab.push_back(plain_row(MODE_SPARE, udec_pkg::REQ_DATA, 8'h7F));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part; an encoding change waits for the pipe to empty
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].mode != mode_now)
            begin
                drain();
                write_mode(dir_tab[i].mode);
            end
            send_req(dir_tab[i].rtype, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
        end

        // random phases: every code once, then random ones; some phases run with no idling
        rand_base = accepted_reqs;
        next_hold = 300;
        ph = 0;
        while (accepted_reqs - rand_base < RANDOM_ITEMS)
        begin
            m = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
            drain();
            no_idle = (ph % 4 == 2);
            write_mode(m);
            quota = $urandom_range(120, 260);
            start = accepted_reqs;
            while (accepted_reqs - start < quota && accepted_reqs - rand_base < RANDOM_ITEMS)
            begin
                // long receiver hold-off while requests keep coming
                if (accepted_reqs - rand_base >= next_hold)
                begin
                    holds_asked++;
                    next_hold += 800;
                end
                send_char(m);
            end
            ph++;
        end

        drain();
        if (errors == 0 && chars_due.size() == 0)
            $display("utf_multi_format_decoder test passed");
        else
            $display("utf_multi_format_decoder test failed");
        $finish;
    end

endmodule
